// ----- sv/video_container_to_annexb_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIDEO_CONTAINER_TO_ANNEXB_DEFRAMER_DEFINES_SVH
`define VIDEO_CONTAINER_TO_ANNEXB_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define VCAD_ASSERT_NOW(lbl, pre, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (cond)) else $error(msg);

// next-cycle implication
`define VCAD_ASSERT_NXT(lbl, pre, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (cond)) else $error(msg);

`endif

// ----- sv/vcad_pkg.sv -----
// ----------------------------------------------------------------------------
// Deframer package
// Types and constants shared by the header window, the queue cells and the top.
// ----------------------------------------------------------------------------
package vcad_pkg;

  localparam int HDR_BYTES     = 48;
  localparam int QW            = 6;   // header byte index, headers stay below 64 bytes
  localparam int LEN_W         = 24;
  localparam int TRAILER_BYTES = 8;
  localparam int QUEUE_SLACK   = 16;

  localparam logic [7:0] MAGIC0  = 8'h44;
  localparam logic [7:0] MAGIC1  = 8'h48;
  localparam logic [7:0] MAGIC2  = 8'h41;
  localparam logic [7:0] MAGIC3  = 8'h56;
  localparam logic [7:0] AUX_TAG = 8'hF1;
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  localparam int AUX_POS = 4;
  localparam int LEN_LO  = 12;
  localparam int LEN_MID = 13;
  localparam int LEN_HI  = 14;

  localparam int NUM_SC = 4;
  // start code offsets, first to try in the lowest bits
  localparam logic [NUM_SC*QW-1:0] SC_OFFS = {6'd40, 6'd36, 6'd32, 6'd28};

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_MAGIC = 3'd1;
  localparam logic [2:0] ERR_NOSC  = 3'd2;
  localparam logic [2:0] ERR_SHORT = 3'd3;
  localparam logic [2:0] ERR_TRUNC = 3'd4;

  typedef struct packed {
    logic          valid;
    logic          pend;
    logic          keep;
    logic          flast;
    logic          rlast;
    logic [2:0]    err;
    logic [QW-1:0] q;
    logic [7:0]    data;
  } entry_t;

  typedef struct packed {
    logic [1:0] n;
    entry_t     e0;
    entry_t     e1;
  } push_t;

  typedef struct packed {
    logic          en;
    logic          keep_en;
    logic          rl_ok;
    logic          exact;
    logic [QW-1:0] s;
    logic [QW-1:0] lim;
  } res_t;

  typedef struct packed {
    logic             magic_ok;
    logic             aux;
    logic             sc_found;
    logic [QW-1:0]    sc_off;
    logic [LEN_W-1:0] len;
  } hdr_info_t;

endpackage

// ----- sv/vcad_hdr.sv -----
// ----------------------------------------------------------------------------
// Header window
// Shift line of header bytes with the magic, aux tag, length and start code decode.
// ----------------------------------------------------------------------------
module vcad_hdr
  import vcad_pkg::*;
#(
  parameter int HB = HDR_BYTES
) (
  input  logic      clk,
  input  logic      shift_en,
  input  logic [7:0] in_byte,
  output hdr_info_t info
);

  logic [7:0]        win_r [HB-1];
  logic [7:0]        full  [HB];
  logic [NUM_SC-1:0] sc_hit;

  for (genvar j = 0; j < HB - 1; j++) begin : g_win
    if (j == HB - 2) begin : g_tail
      always_ff @(posedge clk) begin
        if (shift_en) begin
          win_r[j] <= in_byte;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (shift_en) begin
          win_r[j] <= win_r[j+1];
        end
      end
    end
    assign full[j] = win_r[j];
  end
  assign full[HB-1] = in_byte;

  for (genvar k = 0; k < NUM_SC; k++) begin : g_sc
    localparam int O = int'(SC_OFFS[k*QW +: QW]);
    assign sc_hit[k] = (full[O] == SC_ZERO) && (full[O+1] == SC_ZERO) &&
                       (full[O+2] == SC_ZERO) && (full[O+3] == SC_ONE);
  end

  always_comb begin
    info.magic_ok = (full[0] == MAGIC0) && (full[1] == MAGIC1) &&
                    (full[2] == MAGIC2) && (full[3] == MAGIC3);
    info.aux      = (full[AUX_POS] == AUX_TAG);
    info.len      = {full[LEN_HI], full[LEN_MID], full[LEN_LO]};
    info.sc_found = |sc_hit;
    info.sc_off   = '0;
    for (int k = NUM_SC - 1; k >= 0; k--) begin
      if (sc_hit[k]) begin
        info.sc_off = SC_OFFS[k*QW +: QW];
      end
    end
  end

endmodule

// ----- sv/vcad_cell.sv -----
// ----------------------------------------------------------------------------
// Queue cell
// One slot of the output queue: shift toward the head, take writes, resolve
// pending header bytes.
// ----------------------------------------------------------------------------
module vcad_cell
  import vcad_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop,
  input  logic [CW-1:0] idx0,
  input  push_t         push,
  input  res_t          res,
  input  entry_t        up,
  output entry_t        cur
);

  entry_t cur_r;
  entry_t cur_nxt;

  always_comb begin
    cur_nxt = pop ? up : cur_r;
    if ((push.n != 2'd0) && (idx0 == CW'(IDX))) begin
      cur_nxt = push.e0;
    end else if ((push.n == 2'd2) && ((idx0 + CW'(1)) == CW'(IDX))) begin
      cur_nxt = push.e1;
    end
    if (res.en && cur_nxt.valid && cur_nxt.pend) begin
      cur_nxt.pend  = 1'b0;
      cur_nxt.keep  = res.keep_en && (cur_nxt.q >= res.s) && (cur_nxt.q <= res.lim);
      cur_nxt.flast = cur_nxt.keep && res.exact && (cur_nxt.q == res.lim);
      cur_nxt.rlast = cur_nxt.keep && res.rl_ok && (cur_nxt.q == res.lim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
      cur_r.pend  <= 1'b0;
    end else begin
      cur_r.valid <= cur_nxt.valid;
      cur_r.pend  <= cur_nxt.pend;
    end
    cur_r.keep  <= cur_nxt.keep;
    cur_r.flast <= cur_nxt.flast;
    cur_r.rlast <= cur_nxt.rlast;
    cur_r.err   <= cur_nxt.err;
    cur_r.q     <= cur_nxt.q;
    cur_r.data  <= cur_nxt.data;
  end

  assign cur = cur_r;

endmodule

// ----- sv/video_container_to_annexb_deframer.sv -----
// An accepted byte is registered into a queue cell; with the queue empty a payload byte is
// presented in the next cycle. Throughput: one byte per cycle in while in_tready is high,
// one queue entry retired per cycle at the head unless pending or stalled by out_tready.
// Reset: synchronous active low, clears mode, counters and cell valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// Container to Annex B deframer
// Checks each header, drops bytes before its start code and the trailer, skips aux frames
// with no start code, streams H.264 payload via queue cells; errors halt until reset.
// ----------------------------------------------------------------------------
`include "video_container_to_annexb_deframer_defines.svh"

module video_container_to_annexb_deframer
  import vcad_pkg::*;
#(
  parameter int HEADER_BYTES = HDR_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // frame_last
  output logic [3:0] out_tuser   // [0] run_last, [3:1] error_code
);

  localparam int DEPTH = HEADER_BYTES + QUEUE_SLACK;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_HDR  = 2'd0;
  localparam logic [1:0] MODE_PAY  = 2'd1;
  localparam logic [1:0] MODE_SKIP = 2'd2;
  localparam logic [1:0] MODE_HALT = 2'd3;

  logic [1:0]       mode_r,  mode_nxt;
  logic [LEN_W-1:0] pos_r,   pos_nxt;
  logic [LEN_W-1:0] len_r,   len_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  logic             in_fire;
  logic             pop;
  logic             hdr_shift;
  logic             last_hdr;
  logic             hit;
  logic             byte_push;
  logic [2:0]       err;
  logic [LEN_W-1:0] lim_full;
  logic [CW-1:0]    idx0;
  entry_t           byte_e;
  entry_t           err_e;
  push_t            push;
  res_t             res;
  hdr_info_t        info;
  entry_t           cell_q [DEPTH];

  assign in_tready = (count_r <= CW'(DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign last_hdr  = (pos_r == LEN_W'(HEADER_BYTES - 1));
  assign hdr_shift = in_fire && (mode_r == MODE_HDR);

  vcad_hdr #(
    .HB(HEADER_BYTES)
  ) u_hdr (
    .clk      (clk),
    .shift_en (hdr_shift),
    .in_byte  (in_tdata),
    .info     (info)
  );

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    err       = ERR_NONE;
    hit       = 1'b0;
    byte_push = 1'b0;
    byte_e    = '0;
    if (in_fire) begin
      unique case (mode_r)
        MODE_HDR: begin
          byte_push    = 1'b1;
          byte_e.valid = 1'b1;
          byte_e.pend  = 1'b1;
          byte_e.q     = pos_r[QW-1:0];
          byte_e.data  = in_tdata;
          if (last_hdr) begin
            pos_nxt = LEN_W'(HEADER_BYTES);
            if (!info.magic_ok) begin
              err = ERR_MAGIC;
            end else begin
              len_nxt = info.len;
              if (info.len < LEN_W'(HEADER_BYTES)) begin
                err = ERR_SHORT;
              end else if (!info.sc_found) begin
                if (info.aux) begin
                  mode_nxt = MODE_SKIP;
                end else begin
                  err = ERR_NOSC;
                end
              end else if (info.len < (LEN_W'(info.sc_off) + LEN_W'(TRAILER_BYTES))) begin
                err = ERR_SHORT;
              end else begin
                mode_nxt = MODE_PAY;
                hit      = 1'b1;
              end
            end
          end else begin
            pos_nxt = pos_r + LEN_W'(1);
          end
        end
        MODE_PAY: begin
          if (({1'b0, pos_r} + (LEN_W+1)'(TRAILER_BYTES)) < {1'b0, len_r}) begin
            byte_push    = 1'b1;
            byte_e.valid = 1'b1;
            byte_e.keep  = 1'b1;
            byte_e.data  = in_tdata;
            byte_e.flast = (({1'b0, pos_r} + (LEN_W+1)'(TRAILER_BYTES + 1)) ==
                            {1'b0, len_r});
          end
          pos_nxt = pos_r + LEN_W'(1);
        end
        MODE_SKIP: begin
          pos_nxt = pos_r + LEN_W'(1);
        end
        MODE_HALT: begin
        end
      endcase
      if (mode_r != MODE_HALT) begin
        if ((err == ERR_NONE) && (mode_nxt != MODE_HDR) && (pos_nxt >= len_nxt)) begin
          mode_nxt = MODE_HDR;
          pos_nxt  = '0;
        end
        if ((err == ERR_NONE) && in_tlast && ((mode_nxt != MODE_HDR) || (pos_nxt != '0))) begin
          err = ERR_TRUNC;
        end
        if (err != ERR_NONE) begin
          mode_nxt = MODE_HALT;
        end
      end
    end
    byte_e.rlast = (err == ERR_NONE);
  end

  always_comb begin
    err_e       = '0;
    err_e.valid = 1'b1;
    err_e.keep  = 1'b1;
    err_e.rlast = 1'b1;
    err_e.err   = err;
    push.n      = 2'(byte_push) + 2'(err != ERR_NONE);
    push.e0     = byte_push ? byte_e : err_e;
    push.e1     = err_e;
  end

  assign lim_full = len_nxt - LEN_W'(TRAILER_BYTES + 1);

  always_comb begin
    res.en      = hdr_shift && (last_hdr || (err != ERR_NONE));
    res.keep_en = hit;
    res.rl_ok   = (err == ERR_NONE);
    res.s       = info.sc_off;
    res.exact   = (len_nxt <= LEN_W'(HEADER_BYTES + TRAILER_BYTES));
    res.lim     = res.exact ? lim_full[QW-1:0] : QW'(HEADER_BYTES - 1);
  end

  assign pop  = cell_q[0].valid && !cell_q[0].pend && (!cell_q[0].keep || out_tready);
  assign idx0 = count_r - CW'(pop);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t up;
    if (i == DEPTH - 1) begin : g_top
      assign up = '0;
    end else begin : g_body
      assign up = cell_q[i+1];
    end
    vcad_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .pop   (pop),
      .idx0  (idx0),
      .push  (push),
      .res   (res),
      .up    (up),
      .cur   (cell_q[i])
    );
  end

  assign count_nxt = idx0 + CW'(push.n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HDR;
      pos_r   <= '0;
      len_r   <= '0;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_tvalid = cell_q[0].valid && !cell_q[0].pend && cell_q[0].keep;
  assign out_tdata  = cell_q[0].data;
  assign out_tlast  = cell_q[0].flast;
  assign out_tuser  = {cell_q[0].err, cell_q[0].rlast};

  `VCAD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "queue count beyond depth")
  `VCAD_ASSERT_NOW(a_err_ends_run, out_tvalid && (out_tuser[3:1] != ERR_NONE), out_tuser[0] && !out_tlast && (mode_r == MODE_HALT), "error transaction outside halt")
  `VCAD_ASSERT_NXT(a_halt_quiet, (mode_r == MODE_HALT) && (count_r == '0), !out_tvalid && (mode_r == MODE_HALT), "output after halt drained")

endmodule
